[hdl/slcd_pkg.sv]
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared constants, types and helpers for the serial mono LCD controller.
// ----------------------------------------------------------------------------
package slcd_pkg;

  // Display geometry
  localparam int NumColumns = 84;
  localparam int NumBanks   = 6;
  localparam int RamDepth   = NumColumns * NumBanks;
  localparam int AddrW      = $clog2(RamDepth);
  localparam int ColW       = 7;
  localparam int BankW      = 3;
  localparam int RowW       = 6;
  localparam int NumRows    = NumBanks * 8;

  // Command decode masks and patterns
  localparam logic [7:0] CMD_FSET_MASK = 8'hF8;
  localparam logic [7:0] CMD_FSET      = 8'h20;
  localparam logic [7:0] CMD_DCTL_MASK = 8'hFA;
  localparam logic [7:0] CMD_DCTL      = 8'h08;
  localparam logic [7:0] CMD_BANK_MASK = 8'hF8;
  localparam logic [7:0] CMD_BANK      = 8'h40;
  localparam logic [7:0] CMD_COL_MASK  = 8'h80;
  localparam logic [7:0] CMD_COL       = 8'h80;

  // Display state codes
  localparam logic [2:0] DS_POWER_DOWN = 3'd0;
  localparam logic [2:0] DS_BLANK      = 3'd1;
  localparam logic [2:0] DS_ALL_ON     = 3'd2;
  localparam logic [2:0] DS_NORMAL     = 3'd3;
  localparam logic [2:0] DS_INVERSE    = 3'd4;

  // Controller register file
  typedef struct packed {
    logic [ColW-1:0]  col;
    logic [BankW-1:0] bank;
    logic             ext;
    logic             vert;
    logic             pd;
    logic             d_bit;
    logic             e_bit;
  } ctrl_state_t;

  // One pin sample
  typedef struct packed {
    logic rst_n;
    logic cs_n;
    logic dc;
    logic din;
    logic sclk;
  } pins_t;

  // Display RAM write request
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } ram_wr_t;

  function automatic logic [2:0] disp_state(input ctrl_state_t s);
    logic [2:0] st;
    priority if (s.pd)      st = DS_POWER_DOWN;
    else if (!s.d_bit)      st = s.e_bit ? DS_ALL_ON : DS_BLANK;
    else                    st = s.e_bit ? DS_INVERSE : DS_NORMAL;
    return st;
  endfunction

endpackage

[hdl/slcd_if.sv]
// ----------------------------------------------------------------------------
// slcd_if
// Valid/ready channels for pin samples / pixel reads and for results.
// ----------------------------------------------------------------------------
interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       rst_n;
  logic       cs_n;
  logic       dc;
  logic       din;
  logic       sclk;
  logic [6:0] pixel_col;
  logic [5:0] pixel_row;

  modport source (output valid, mode, rst_n, cs_n, dc, din, sclk, pixel_col, pixel_row,
                  input ready);
  modport sink   (input valid, mode, rst_n, cs_n, dc, din, sclk, pixel_col, pixel_row,
                  output ready);
endinterface

interface slcd_out_if;
  logic       valid;
  logic       ready;
  logic       pixel;
  logic [2:0] display_state;
  logic [6:0] column_pointer;
  logic [2:0] bank_pointer;

  modport source (output valid, pixel, display_state, column_pointer, bank_pointer,
                  input ready);
  modport sink   (input valid, pixel, display_state, column_pointer, bank_pointer,
                  output ready);
endinterface

[hdl/slcd_ram.sv]
// ----------------------------------------------------------------------------
// slcd_ram
// Display RAM: one write port, one registered read port with enable.
// ----------------------------------------------------------------------------
module slcd_ram (
  input  logic                            clk,
  input  slcd_pkg::ram_wr_t               wr,
  input  logic                            rd_en,
  input  logic [slcd_pkg::AddrW-1:0]      rd_addr,
  output logic [7:0]                      rd_data
);

  logic [7:0] mem [slcd_pkg::RamDepth];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/slcd_regs.sv]
// ----------------------------------------------------------------------------
// slcd_regs
// Serial shifter, command decoder and address counters of the controller.
// ----------------------------------------------------------------------------
module slcd_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  slcd_pkg::pins_t        pins,
  output slcd_pkg::ctrl_state_t  state,
  output slcd_pkg::ram_wr_t      wr
);

  logic [7:0]            shift_byte, shift_byte_next;
  logic [2:0]            bit_count, bit_count_next;
  logic                  last_clock, last_clock_next;
  slcd_pkg::ctrl_state_t state_next;

  logic [7:0]                 sb;
  logic [slcd_pkg::ColW:0]    col_inc;
  logic [slcd_pkg::BankW:0]   bank_inc;
  logic [slcd_pkg::BankW:0]   cmd_bank;
  logic [slcd_pkg::ColW:0]    cmd_col;

  assign sb       = {shift_byte[7:1], pins.din};
  assign col_inc  = {1'b0, state.col} + 1'b1;
  assign bank_inc = {1'b0, state.bank} + 1'b1;
  assign cmd_bank = {1'b0, sb[2:0]};
  assign cmd_col  = {1'b0, sb[6:0]};

  // Next-state logic for one pin sample
  always_comb begin
    shift_byte_next = shift_byte;
    bit_count_next  = bit_count;
    last_clock_next = last_clock;
    state_next      = state;
    wr.en           = 1'b0;
    wr.addr         = slcd_pkg::AddrW'(state.bank) * slcd_pkg::AddrW'(slcd_pkg::NumColumns)
                    + slcd_pkg::AddrW'(state.col);
    wr.data         = sb;
    if (step) begin
      priority if (!pins.rst_n) begin
        shift_byte_next  = '0;
        bit_count_next   = '0;
        state_next       = '0;
        state_next.pd    = 1'b1;
      end else if (pins.cs_n) begin
        shift_byte_next = '0;
        bit_count_next  = '0;
      end else if (!pins.sclk) begin
        last_clock_next = 1'b0;
      end else if (!last_clock) begin
        last_clock_next = 1'b1;
        if (bit_count == 3'd7) begin
          shift_byte_next = sb;
          bit_count_next  = '0;
          if (pins.dc) begin
            // data byte: write, then auto-increment
            wr.en = 1'b1;
            if (state.vert) begin
              if (bank_inc >= (slcd_pkg::BankW+1)'(slcd_pkg::NumBanks)) begin
                state_next.bank = '0;
                state_next.col  = (col_inc >= (slcd_pkg::ColW+1)'(slcd_pkg::NumColumns))
                                ? '0 : col_inc[slcd_pkg::ColW-1:0];
              end else begin
                state_next.bank = bank_inc[slcd_pkg::BankW-1:0];
              end
            end else begin
              if (col_inc >= (slcd_pkg::ColW+1)'(slcd_pkg::NumColumns)) begin
                state_next.col  = '0;
                state_next.bank = (bank_inc >= (slcd_pkg::BankW+1)'(slcd_pkg::NumBanks))
                                ? '0 : bank_inc[slcd_pkg::BankW-1:0];
              end else begin
                state_next.col = col_inc[slcd_pkg::ColW-1:0];
              end
            end
          end else begin
            // command decode
            priority if ((sb & slcd_pkg::CMD_FSET_MASK) == slcd_pkg::CMD_FSET) begin
              state_next.ext  = sb[0];
              state_next.vert = sb[1];
              state_next.pd   = sb[2];
            end else if (state.ext) begin
              // extended set: ignored
            end else if ((sb & slcd_pkg::CMD_DCTL_MASK) == slcd_pkg::CMD_DCTL) begin
              state_next.d_bit = sb[2];
              state_next.e_bit = sb[0];
            end else if ((sb & slcd_pkg::CMD_BANK_MASK) == slcd_pkg::CMD_BANK) begin
              if (cmd_bank < (slcd_pkg::BankW+1)'(slcd_pkg::NumBanks)) begin
                state_next.bank = sb[slcd_pkg::BankW-1:0];
              end
            end else if ((sb & slcd_pkg::CMD_COL_MASK) == slcd_pkg::CMD_COL) begin
              if (cmd_col < (slcd_pkg::ColW+1)'(slcd_pkg::NumColumns)) begin
                state_next.col = sb[slcd_pkg::ColW-1:0];
              end
            end else begin
              // unknown command: ignored
            end
          end
        end else begin
          shift_byte_next = {sb[6:0], 1'b0};
          bit_count_next  = bit_count + 3'd1;
        end
      end else begin
        // sclk held high: nothing
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte <= '0;
      bit_count  <= '0;
      last_clock <= 1'b0;
      state      <= '{col: '0, bank: '0, ext: 1'b0, vert: 1'b0, pd: 1'b1,
                      d_bit: 1'b0, e_bit: 1'b0};
    end else begin
      shift_byte <= shift_byte_next;
      bit_count  <= bit_count_next;
      last_clock <= last_clock_next;
      state      <= state_next;
    end
  end

endmodule

[hdl/serial_mono_lcd_controller_top.sv]
// ----------------------------------------------------------------------------
// serial_mono_lcd_controller_top
// Serial graphic LCD controller, 84x48 pixels, with display RAM and reader.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per pin sample (mode 0) or pixel read (mode 1).
//   out_ch returns exactly one word per input word, in order: the rendered
//   pixel (0 for pin samples), the display state and the RAM column/bank
//   pointers as they stand after that word.
//   One word is accepted every cycle while out_ch does not stall; the pipeline
//   is an input register followed by a result register that also holds the
//   registered display RAM read data.
//   After rst the display RAM is swept to zero, one entry a cycle, over all
//   504 entries; in_ch.ready stays low during that sweep. The rst_n field of
//   a pin sample resets the controller registers but leaves the RAM intact.
//   When out_ch stalls, the whole pipeline holds and in_ch.ready drops in
//   the same cycle, so no word is lost or repeated.
// ----------------------------------------------------------------------------
module serial_mono_lcd_controller_top (
  input  logic          clk,
  input  logic          rst,
  slcd_in_if.sink       in_ch,
  slcd_out_if.source    out_ch
);

  // Pipeline control
  logic advance;
  logic a_valid, b_valid;
  logic clearing;
  logic [slcd_pkg::AddrW-1:0] clr_addr;

  // Input register
  logic                      a_mode;
  slcd_pkg::pins_t           a_pins;
  logic [slcd_pkg::ColW-1:0] a_col;
  logic [slcd_pkg::RowW-1:0] a_row;

  // Result register
  logic       b_rd;
  logic       b_in_range;
  logic [2:0] b_bit_sel;
  logic [7:0] ram_q;

  slcd_pkg::ctrl_state_t state;
  slcd_pkg::ram_wr_t     ctrl_wr, ram_wr;
  logic                  a_in_range;
  logic [slcd_pkg::AddrW-1:0] rd_addr;
  logic [2:0]            st;
  logic                  ram_bit;

  assign advance     = !b_valid || out_ch.ready;
  assign in_ch.ready = advance && !clearing;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_ch.valid && in_ch.ready;
    end
    if (in_ch.ready) begin
      a_mode  <= in_ch.mode;
      a_pins  <= '{rst_n: in_ch.rst_n, cs_n: in_ch.cs_n, dc: in_ch.dc,
                   din: in_ch.din, sclk: in_ch.sclk};
      a_col   <= in_ch.pixel_col;
      a_row   <= in_ch.pixel_row;
    end
  end

  // Controller registers step on pin samples only
  slcd_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .step  (advance && a_valid && !a_mode),
    .pins  (a_pins),
    .state (state),
    .wr    (ctrl_wr)
  );

  // RAM clear sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == slcd_pkg::AddrW'(slcd_pkg::RamDepth - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      ram_wr = '{en: 1'b1, addr: clr_addr, data: 8'h00};
    end else begin
      ram_wr = ctrl_wr;
    end
  end

  // Pixel read address
  assign a_in_range = ({1'b0, a_col} < (slcd_pkg::ColW+1)'(slcd_pkg::NumColumns))
                   && ({1'b0, a_row} < (slcd_pkg::RowW+1)'(slcd_pkg::NumRows));
  assign rd_addr = a_in_range
                 ? slcd_pkg::AddrW'(a_row[slcd_pkg::RowW-1:3])
                     * slcd_pkg::AddrW'(slcd_pkg::NumColumns)
                   + slcd_pkg::AddrW'(a_col)
                 : '0;

  slcd_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_en   (advance),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Result register; pointers and state come straight from the controller
  // registers, which change only when a new word moves into this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
    end
    if (advance) begin
      b_rd       <= a_mode;
      b_in_range <= a_in_range;
      b_bit_sel  <= a_row[2:0];
    end
  end

  // Pixel rendering
  assign st      = slcd_pkg::disp_state(state);
  assign ram_bit = ram_q[b_bit_sel];

  always_comb begin
    out_ch.pixel = 1'b0;
    if (b_rd && b_in_range) begin
      unique case (st)
        slcd_pkg::DS_ALL_ON:  out_ch.pixel = 1'b1;
        slcd_pkg::DS_NORMAL:  out_ch.pixel = ram_bit;
        slcd_pkg::DS_INVERSE: out_ch.pixel = !ram_bit;
        default:              out_ch.pixel = 1'b0;
      endcase
    end
  end

  assign out_ch.valid          = b_valid;
  assign out_ch.display_state  = st;
  assign out_ch.column_pointer = state.col;
  assign out_ch.bank_pointer   = state.bank;

`ifndef SYNTHESIS
  a_reset_sweep: assert property (@(posedge clk) rst |=> clearing && !b_valid && !a_valid)
    else $error("reset did not start RAM sweep");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
      clearing |-> !in_ch.ready)
    else $error("word accepted during RAM sweep");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
      (state.col < slcd_pkg::ColW'(slcd_pkg::NumColumns))
      && (state.bank < slcd_pkg::BankW'(slcd_pkg::NumBanks)))
    else $error("RAM pointer out of range");
  a_pin_pixel_zero: assert property (@(posedge clk) disable iff (rst)
      out_ch.valid && !b_rd |-> !out_ch.pixel)
    else $error("pin sample returned a dark pixel");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
      out_ch.valid && !out_ch.ready |=> $stable(state) && b_valid)
    else $error("controller state moved while result stalled");
`endif

endmodule
